// ----- src/tscd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_pkg
// shared types, constants and the crc-8 byte update for the scratchpad decoder
// ----------------------------------------------------------------------------
package tscd_pkg;

  localparam logic [7:0]  CRC_POLY       = 8'h8C;
  localparam logic [3:0]  LAST_INDEX     = 4'd8;
  localparam logic [7:0]  ALL_ONES_BYTE  = 8'hFF;
  localparam logic [15:0] RESET_READING  = 16'h0550;
  localparam logic [7:0]  DEF_ALARM_HIGH = 8'h4B;
  localparam logic [7:0]  DEF_ALARM_LOW  = 8'h46;

  localparam logic [1:0] STATUS_OK            = 2'd0;
  localparam logic [1:0] STATUS_BAD_CRC       = 2'd1;
  localparam logic [1:0] STATUS_NOT_CONVERTED = 2'd2;
  localparam logic [1:0] STATUS_DISCONNECTED  = 2'd3;

  localparam logic [1:0] RES_9BIT  = 2'd0;
  localparam logic [1:0] RES_10BIT = 2'd1;
  localparam logic [1:0] RES_11BIT = 2'd2;

  // outcome of one byte: last marks byte 8, which carries a result
  typedef struct packed {
    logic              last;
    logic [1:0]        status;
    logic signed [15:0] temperature;
  } tscd_result_t;

  // reflected crc-8, lsb first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] value);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ value[i];
      crc = {1'b0, crc[7:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

// ----- src/temp_scratchpad_crc_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_scratchpad_crc_decoder
// decodes a nine-byte temperature sensor scratchpad with crc-8 check
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                 | tuser
//  in_     | slave     | [7:0] scratch_byte                 | frame_start
//  out_    | master    | [1:0] decode_status, [17:2] temp   | -
//
//  one byte accepted per cycle unless a stalled result blocks it; byte 8 passes
//  the input register, then is decoded into the result register
//  the input register advances whenever the result register is free or
//  being drained, so throughput is set by the single result register
//  synchronous active-low reset clears the byte counter, crc and valids
//  a stalled result holds; bytes keep flowing until the input register fills
// ----------------------------------------------------------------------------
module temp_scratchpad_crc_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scratch_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] decode_status, [17:2] temperature
);
  import tscd_pkg::*;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r;
  logic [15:0] out_temp_r;

  logic         fire;
  tscd_result_t result;

  // the byte in the input register is consumed when the result slot is free or being drained
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  tscd_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .scratch_byte (in_byte_r),
    .frame_start  (in_start_r),
    .result       (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && result.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && result.last) begin
      out_status_r <= result.status;
      out_temp_r   <= result.temperature;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_temp_r, out_status_r};

  // checks on this block's own pipeline
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.last |=> out_tvalid)
    else $error("byte 8 decision did not reach the result register");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != STATUS_OK) |-> (out_tdata[17:2] == 16'h0000))
    else $error("nonzero temperature on an error status");

  a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !fire |=> in_valid_r && $stable(in_byte_r) && $stable(in_start_r))
    else $error("blocked byte lost from the input register");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("valids not cleared by reset");

endmodule

// ----- src/tscd_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_frame
// byte counter, crc and scratchpad capture with the byte-8 decision
// ----------------------------------------------------------------------------
module tscd_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            scratch_byte,
  input  logic                  frame_start,
  output tscd_pkg::tscd_result_t result
);
  import tscd_pkg::*;

  logic [3:0] count_r, count_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       ones_r, ones_nxt;
  logic [7:0] tlo_r, thi_r, ahi_r, alo_r;
  logic [1:0] res_r;

  logic [3:0]  idx;
  logic [7:0]  crc_base;
  logic        ones_now;
  logic [15:0] raw;
  logic [15:0] masked;

  always_comb begin
    if (frame_start || (count_r > LAST_INDEX)) begin
      idx = 4'd0;
    end else begin
      idx = count_r;
    end
    crc_base = (idx == 4'd0) ? 8'h00 : crc_r;
    ones_now = ((idx == 4'd0) ? 1'b1 : ones_r) && (scratch_byte == ALL_ONES_BYTE);
    ones_nxt = ones_now;
    if (idx < LAST_INDEX) begin
      crc_nxt   = crc8_update(crc_base, scratch_byte);
      count_nxt = idx + 4'd1;
    end else begin
      crc_nxt   = crc_base;
      count_nxt = 4'd0;
    end
  end

  // decision on byte 8, using bytes captured earlier in this frame
  always_comb begin
    raw = {thi_r, tlo_r};
    case (res_r)
      RES_9BIT:  masked = raw & 16'hFFF8;
      RES_10BIT: masked = raw & 16'hFFFC;
      RES_11BIT: masked = raw & 16'hFFFE;
      default:   masked = raw;
    endcase
    result.last        = (idx == LAST_INDEX);
    result.temperature = '0;
    if (ones_now) begin
      result.status = STATUS_DISCONNECTED;
    end else if (crc_base != scratch_byte) begin
      result.status = STATUS_BAD_CRC;
    end else if ((masked == RESET_READING) && (ahi_r == DEF_ALARM_HIGH) &&
                 (alo_r == DEF_ALARM_LOW)) begin
      result.status = STATUS_NOT_CONVERTED;
    end else begin
      result.status      = STATUS_OK;
      result.temperature = masked;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd0;
      crc_r   <= 8'h00;
      ones_r  <= 1'b1;
    end else if (fire) begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      ones_r  <= ones_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      case (idx)
        4'd0:    tlo_r <= scratch_byte;
        4'd1:    thi_r <= scratch_byte;
        4'd2:    ahi_r <= scratch_byte;
        4'd3:    alo_r <= scratch_byte;
        4'd4:    res_r <= scratch_byte[6:5];
        default: ;
      endcase
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the scratchpad crc decoder: streams scratchpad
// bytes with random gaps and back-pressure, predicts each decoded reading
// in a local model of the decoder and checks every result in order
// ----------------------------------------------------------------------------
module tb_top;
  import tscd_pkg::*;

  localparam int N_ITEMS      = 750;  // rough stimulus length, random part
  localparam int DRAIN_CYCLES = 20;   // byte 8 passes the input register, then the result register
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_ITEMS   = 100;  // no idling for the last bytes

  typedef struct {
    logic [7:0] value;
    logic       start;
  } scratch_item_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [15:0] temp;
  } reading_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // dut ports, inputs known from time zero
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] scratch_byte
  logic        in_tuser   = 1'b0;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;           // [1:0] decode_status, [17:2] temperature

  // bytes still to send and readings still to arrive
  scratch_item_t pending_bytes[$];
  reading_t      expected_readings[$];

  // handshake bookkeeping between the sampling and the driving edge
  logic in_taken  = 1'b0;
  int   in_gap    = 0;
  int   out_stall = 0;
  int   fail_cnt  = 0;

  // local copy of the decoder state
  logic [3:0] sp_count    = 4'd0;
  logic [7:0] sp_crc      = 8'h00;
  logic       sp_all_ff   = 1'b1;
  logic [7:0] sp_temp_lsb = 8'h00;
  logic [7:0] sp_temp_msb = 8'h00;
  logic [7:0] sp_alarm_hi = 8'h00;
  logic [7:0] sp_alarm_lo = 8'h00;
  logic [1:0] sp_res      = 2'd0;

  temp_scratchpad_crc_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // reflected crc-8, data folded in first, then shifted out lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // advance the local decoder by one accepted byte, queue a reading on byte 8
  function automatic void decode_byte(input logic [7:0] value, input logic start);
    logic [3:0]  idx;
    logic [15:0] raw;
    reading_t    r;
    if (start) begin
      sp_count = 4'd0;
    end
    idx = (sp_count > LAST_INDEX) ? 4'd0 : sp_count;
    // byte 0 restarts the crc and the all-ones tracking
    if (idx == 4'd0) begin
      sp_crc    = 8'h00;
      sp_all_ff = 1'b1;
    end
    if (value != ALL_ONES_BYTE) begin
      sp_all_ff = 1'b0;
    end
    if (idx < LAST_INDEX) begin
      sp_crc = crc8_byte(sp_crc, value);
      case (idx)
        4'd0: sp_temp_lsb = value;
        4'd1: sp_temp_msb = value;
        4'd2: sp_alarm_hi = value;
        4'd3: sp_alarm_lo = value;
        4'd4: sp_res      = value[6:5];
        default: ;
      endcase
      sp_count = idx + 4'd1;
    end else begin
      raw = {sp_temp_msb, sp_temp_lsb};
      // undefined low bits are cleared at lower resolutions
      case (sp_res)
        RES_9BIT:  raw[2:0] = 3'b000;
        RES_10BIT: raw[1:0] = 2'b00;
        RES_11BIT: raw[0]   = 1'b0;
        default: ;
      endcase
      r.temp = '0;
      if (sp_all_ff) begin
        r.status = STATUS_DISCONNECTED;
      end else if (sp_crc != value) begin
        r.status = STATUS_BAD_CRC;
      end else if (raw == RESET_READING && sp_alarm_hi == DEF_ALARM_HIGH &&
                   sp_alarm_lo == DEF_ALARM_LOW) begin
        r.status = STATUS_NOT_CONVERTED;
      end else begin
        r.status = STATUS_OK;
        r.temp   = raw;
      end
      expected_readings.push_back(r);
      sp_count = 4'd0;
    end
  endfunction

  function automatic void push_item(input logic [7:0] value, input logic start);
    scratch_item_t it;
    it.value = value;
    it.start = start;
    pending_bytes.push_back(it);
  endfunction

  // one scratchpad with a valid crc; fault_pos below 9 flips bits of that byte
  function automatic void push_frame(input logic [7:0] lsb, msb, alarm_hi, alarm_lo,
                                     input logic [7:0] cfg, input logic start,
                                     input int fault_pos, input logic [7:0] fault_mask);
    logic [7:0] fb[9];
    logic [7:0] crc;
    fb[0] = lsb;
    fb[1] = msb;
    fb[2] = alarm_hi;
    fb[3] = alarm_lo;
    fb[4] = cfg;
    // reserved bytes, mostly the usual 0xff in the first one
    fb[5] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : ALL_ONES_BYTE;
    fb[6] = 8'($urandom);
    fb[7] = 8'($urandom);
    crc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      crc = crc8_byte(crc, fb[k]);
    end
    fb[8] = crc;
    if (fault_pos < 9) begin
      fb[fault_pos] = fb[fault_pos] ^ fault_mask;
    end
    for (int k = 0; k < 9; k++) begin
      push_item(fb[k], start && (k == 0));
    end
  endfunction

  // idling off in the tail and in every third stretch of 50 bytes
  function automatic logic idling_allowed();
    return pending_bytes.size() >= TAIL_ITEMS && ((pending_bytes.size() / 50) % 3) != 0;
  endfunction

  // sampling edge: predict accepted bytes, check accepted results
  always @(posedge clk) begin
    reading_t   exp_r;
    logic [1:0] got_status;
    logic [15:0] got_temp;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tuser);
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got_status = out_tdata[1:0];
        got_temp   = out_tdata[17:2];
        if (expected_readings.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("mismatch: result with none expected, status %0d temperature %0d",
                     got_status, $signed(got_temp));
          end
        end else begin
          exp_r = expected_readings.pop_front();
          if (got_status !== exp_r.status || got_temp !== exp_r.temp) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS) begin
              $display("mismatch: status exp %0d got %0d, temperature exp %0d got %0d",
                       exp_r.status, got_status, exp_r.temp, $signed(got_temp));
            end
          end
        end
      end
    end
  end

  // input driver: hold a byte until its transaction, then a gap or the next byte
  always @(negedge clk) begin
    scratch_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 11) - 1;
        in_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        it = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= it.value;
        in_tuser  <= it.start;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
      out_stall = $urandom_range(1, 11) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int          kind;
    int          directed_cnt;
    logic [15:0] reading;
    logic [7:0]  alarm_hi;
    logic [7:0]  alarm_lo;

    // disconnected sensor: all nine bytes read as 0xff
    for (int k = 0; k < 9; k++) begin
      push_item(ALL_ONES_BYTE, k == 0);
    end
    // a broken run of three zero bytes, cut short by a frame restart
    for (int k = 0; k < 3; k++) begin
      push_item(8'h00, 1'b0);
    end
    // power-on reading with default alarms at 12-bit resolution
    push_frame(RESET_READING[7:0], RESET_READING[15:8], DEF_ALARM_HIGH, DEF_ALARM_LOW,
               8'h7F, 1'b1, 9, 8'h00);
    // most negative reading, 9-bit, no frame start: implicit next frame
    push_frame(8'h07, 8'h80, 8'h00, 8'hFF, 8'h1F, 1'b0, 9, 8'h00);
    directed_cnt = pending_bytes.size();

    while (pending_bytes.size() < directed_cnt + N_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // well-formed scratchpad, sometimes bent on purpose
        case ($urandom_range(0, 7))
          0: reading = RESET_READING | 16'($urandom_range(0, 7));
          1: reading = 16'h7FFF;
          2: reading = 16'h8000;
          3: reading = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
          default: reading = 16'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0) begin
          alarm_hi = DEF_ALARM_HIGH;
          alarm_lo = DEF_ALARM_LOW;
        end else begin
          alarm_hi = 8'($urandom);
          alarm_lo = 8'($urandom);
        end
        if (kind < 65) begin
          push_frame(reading[7:0], reading[15:8], alarm_hi, alarm_lo, 8'($urandom),
                     $urandom_range(0, 3) != 0, 9, 8'h00);
        end else begin
          // corrupted byte somewhere in the frame or in the crc itself
          push_frame(reading[7:0], reading[15:8], alarm_hi, alarm_lo, 8'($urandom),
                     $urandom_range(0, 3) != 0, $urandom_range(0, 8),
                     8'($urandom_range(1, 255)));
        end
      end else if (kind < 85) begin
        // bus stuck high, now and then with one byte off
        for (int k = 0; k < 9; k++) begin
          push_item((k == 8 && $urandom_range(0, 2) == 0) ? 8'($urandom) : ALL_ONES_BYTE,
                    k == 0);
        end
      end else if (kind < 95) begin
        // partial frame, restarted only if the next item carries a frame start
        for (int k = $urandom_range(1, 8); k > 0; k--) begin
          push_item(8'($urandom), 1'b0);
        end
      end else begin
        // noise with stray frame starts
        for (int k = $urandom_range(1, 6); k > 0; k--) begin
          push_item(8'($urandom), $urandom_range(0, 2) == 0);
        end
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_tvalid) begin
      @(posedge clk);
    end
    while (expected_readings.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && expected_readings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- temp_scratchpad_crc_decoder.f -----
src/tscd_pkg.sv
src/tscd_frame.sv
src/temp_scratchpad_crc_decoder.sv
verif/tb_top.sv
